// ----- hw/rtl/rgb_luma_tone_curve_unit_assert.svh -----
// Assertion helpers for the tone curve unit.
`ifndef RGB_LUMA_TONE_CURVE_UNIT_ASSERT_SVH
`define RGB_LUMA_TONE_CURVE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define RLTC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rltc assertion failed");
`define RLTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rltc assertion failed");
`else
`define RLTC_ASSERT(lbl, clk, rst_n, prop)
`define RLTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/rltc_pkg.sv -----
package rltc_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int VAL_W          = FRAC_BITS + 1;
  localparam int MAX_POINTS_DEF = 16;
  localparam int NUM_CURVES     = 4;
  localparam int CNT_W          = 5;
  localparam int PIDX_W         = 4;
  localparam int CFG_AW         = 4;
  localparam int CFG_DW         = 32;
  localparam int PROD_W         = 2 * VAL_W;
  localparam int QUO_W          = VAL_W;
  localparam int DIV_LAT        = QUO_W;
  // compare, set-up, multiply, divide, combine
  localparam int CURVE_LAT      = DIV_LAT + 4;

  localparam int WGT_W    = 16;
  localparam int WGT_FRAC = 16;
  localparam int LPROD_W  = VAL_W + WGT_W;
  localparam int LSUM_W   = LPROD_W + 2;

  localparam logic [WGT_W-1:0] W_RED   = 16'd13933;
  localparam logic [WGT_W-1:0] W_GREEN = 16'd46871;
  localparam logic [WGT_W-1:0] W_BLUE  = 16'd4732;

  localparam logic [VAL_W-1:0]  ONE      = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [LSUM_W-1:0] LUMA_RND = LSUM_W'(1) << (WGT_FRAC - 1);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_MAP   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CRV_RED   = 2'd0,
    CRV_GREEN = 2'd1,
    CRV_BLUE  = 2'd2,
    CRV_LUMA  = 2'd3
  } crv_t;

  typedef struct packed {
    op_t               op;
    crv_t              curve_sel;
    logic [PIDX_W-1:0] point_index;
    logic [VAL_W-1:0]  point_x;
    logic [VAL_W-1:0]  point_y;
    logic [VAL_W-1:0]  red_in;
    logic [VAL_W-1:0]  green_in;
    logic [VAL_W-1:0]  blue_in;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] red_out;
    logic [VAL_W-1:0] green_out;
    logic [VAL_W-1:0] blue_out;
  } out_item_t;

  typedef struct packed {
    logic              en;
    crv_t              sel;
    logic [PIDX_W-1:0] idx;
    logic [VAL_W-1:0]  x;
    logic [VAL_W-1:0]  y;
  } pt_wr_t;

  function automatic logic [VAL_W-1:0] sat_one(input logic [VAL_W-1:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

endpackage

// ----- hw/rtl/rgb_luma_tone_curve_unit.sv -----
// Pixel path: input register, channel curves, luma sum, luma curve, scale, dividers, output.
// Throughput: one pixel per cycle while the output register is not stalled; every stage is a
// register slice advanced together. A point write waits until no pixel is in flight.
// Reset (synchronous, rst_n low) clears point counts and valid bits; point tables
// keep whatever they hold and must be written before use.
`include "rgb_luma_tone_curve_unit_assert.svh"
module rgb_luma_tone_curve_unit #(
  parameter int MAX_POINTS = rltc_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rltc_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rltc_pkg::out_item_t           out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [rltc_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [rltc_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [rltc_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import rltc_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration: one point count per curve, 4-byte stride.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] cnt_r [NUM_CURVES];
  logic [1:0]       cfg_idx;

  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {{(CFG_DW - CNT_W){1'b0}}, cnt_r[cfg_idx]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CURVES; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      cnt_r[cfg_idx] <= cfg_pwdata[CNT_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. The whole pipeline advances unless the output register holds
  // a result that is stalled. A point write is held off while any pixel is in
  // flight, so every pixel sees exactly the tables that preceded it.
  // ---------------------------------------------------------------------------
  logic adv, busy_all, in_acc;
  logic out_valid_r;
  out_item_t out_data_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv || (in_valid && in_data.op == OP_WRITE && busy_all);
  assign in_acc   = in_valid && !in_stall;

  pt_wr_t wr;
  assign wr.en  = in_acc && in_data.op == OP_WRITE;
  assign wr.sel = in_data.curve_sel;
  assign wr.idx = in_data.point_index;
  assign wr.x   = sat_one(in_data.point_x);
  assign wr.y   = sat_one(in_data.point_y);

  // ---------------------------------------------------------------------------
  // Input register: saturate the channels to [0, 1].
  // ---------------------------------------------------------------------------
  logic             p0_v_r;
  logic [VAL_W-1:0] p0_ch_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r <= 1'b0;
    end else if (adv) begin
      p0_v_r <= in_acc && in_data.op == OP_MAP;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_ch_r[0] <= sat_one(in_data.red_in);
      p0_ch_r[1] <= sat_one(in_data.green_in);
      p0_ch_r[2] <= sat_one(in_data.blue_in);
    end
  end

  // ---------------------------------------------------------------------------
  // Per-channel curves, all three in lock step.
  // ---------------------------------------------------------------------------
  logic [2:0]       cv, cbusy;
  logic [VAL_W-1:0] c_ch [3];

  for (genvar c = 0; c < 3; c++) begin : g_chan_curve
    rltc_curve #(
      .MAX_POINTS (MAX_POINTS),
      .CURVE_ID   (crv_t'(c))
    ) u_curve (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .wr    (wr),
      .count (cnt_r[c]),
      .in_v  (p0_v_r),
      .in_x  (p0_ch_r[c]),
      .out_v (cv[c]),
      .out_y (c_ch[c]),
      .busy  (cbusy[c])
    );
  end

  // ---------------------------------------------------------------------------
  // Luma: weighted products, then sum with round-half-up and saturate.
  // ---------------------------------------------------------------------------
  logic               l1_v_r;
  logic [LPROD_W-1:0] l1_pr_r [3];
  logic [VAL_W-1:0]   l1_ch_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_v_r <= 1'b0;
    end else if (adv) begin
      l1_v_r <= cv[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l1_pr_r[0] <= LPROD_W'(c_ch[0]) * LPROD_W'(W_RED);
      l1_pr_r[1] <= LPROD_W'(c_ch[1]) * LPROD_W'(W_GREEN);
      l1_pr_r[2] <= LPROD_W'(c_ch[2]) * LPROD_W'(W_BLUE);
      for (int i = 0; i < 3; i++) begin
        l1_ch_r[i] <= c_ch[i];
      end
    end
  end

  logic [LSUM_W-1:0]          l_sum;
  logic [LSUM_W-WGT_FRAC-1:0] l_raw;
  logic [VAL_W-1:0]           l_luma;

  assign l_sum  = LSUM_W'(l1_pr_r[0]) + LSUM_W'(l1_pr_r[1]) + LSUM_W'(l1_pr_r[2]) + LUMA_RND;
  assign l_raw  = l_sum[LSUM_W-1:WGT_FRAC];
  assign l_luma = (l_raw > (LSUM_W-WGT_FRAC)'(ONE)) ? ONE : l_raw[VAL_W-1:0];

  logic             l2_v_r;
  logic [VAL_W-1:0] l2_luma_r;
  logic [VAL_W-1:0] l2_ch_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l2_v_r <= 1'b0;
    end else if (adv) begin
      l2_v_r <= l1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l2_luma_r <= l_luma;
      for (int i = 0; i < 3; i++) begin
        l2_ch_r[i] <= l1_ch_r[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Luma curve; the channels and the luma ride alongside in a delay line.
  // ---------------------------------------------------------------------------
  logic             y_v, y_busy;
  logic [VAL_W-1:0] y_adj;

  rltc_curve #(
    .MAX_POINTS (MAX_POINTS),
    .CURVE_ID   (CRV_LUMA)
  ) u_luma_curve (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .wr    (wr),
    .count (cnt_r[CRV_LUMA]),
    .in_v  (l2_v_r),
    .in_x  (l2_luma_r),
    .out_v (y_v),
    .out_y (y_adj),
    .busy  (y_busy)
  );

  logic [4*VAL_W-1:0] dl_q;

  rltc_delay #(
    .W (4 * VAL_W),
    .D (CURVE_LAT)
  ) u_side_delay (
    .clk (clk),
    .adv (adv),
    .d   ({l2_ch_r[0], l2_ch_r[1], l2_ch_r[2], l2_luma_r}),
    .q   (dl_q)
  );

  // ---------------------------------------------------------------------------
  // Scale: channel * adjusted, then detect overflow and zero luma.
  // ---------------------------------------------------------------------------
  logic              me_v_r;
  logic [PROD_W-1:0] me_pr_r [3];
  logic [VAL_W-1:0]  me_luma_r, me_adj_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      me_v_r <= 1'b0;
    end else if (adv) begin
      me_v_r <= y_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      me_pr_r[0] <= PROD_W'(dl_q[4*VAL_W-1:3*VAL_W]) * PROD_W'(y_adj);
      me_pr_r[1] <= PROD_W'(dl_q[3*VAL_W-1:2*VAL_W]) * PROD_W'(y_adj);
      me_pr_r[2] <= PROD_W'(dl_q[2*VAL_W-1:VAL_W]) * PROD_W'(y_adj);
      me_luma_r  <= dl_q[VAL_W-1:0];
      me_adj_r   <= y_adj;
    end
  end

  // A quotient at or above 2^VAL_W shows as the upper product bits reaching luma.
  logic              md_v_r, md_zero_r;
  logic [2:0]        md_ovf_r;
  logic [PROD_W-1:0] md_num_r [3];
  logic [VAL_W-1:0]  md_den_r, md_adj_r;
  logic              me_zero;
  logic [2:0]        me_ovf;

  assign me_zero = (me_luma_r == '0);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      me_ovf[i] = (me_pr_r[i][PROD_W-1:QUO_W] >= me_luma_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      md_v_r <= 1'b0;
    end else if (adv) begin
      md_v_r <= me_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        md_num_r[i] <= (me_ovf[i] || me_zero) ? '0 : me_pr_r[i];
      end
      md_ovf_r  <= me_ovf;
      md_zero_r <= me_zero;
      md_den_r  <= me_zero ? VAL_W'(1) : me_luma_r;
      md_adj_r  <= me_adj_r;
    end
  end

  logic [2:0]       dv, dbusy;
  logic [QUO_W-1:0] dq [3];
  logic [VAL_W+1:0] dtag [3];

  for (genvar c = 0; c < 3; c++) begin : g_scale_div
    rltc_div #(
      .DW (VAL_W),
      .QW (QUO_W),
      .TW (VAL_W + 2)
    ) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_v    (md_v_r),
      .num     (md_num_r[c]),
      .den     (md_den_r),
      .tag     ({md_ovf_r[c], md_zero_r, md_adj_r}),
      .out_v   (dv[c]),
      .quo     (dq[c]),
      .out_tag (dtag[c]),
      .busy    (dbusy[c])
    );
  end

  // Zero luma takes the adjusted luma; otherwise clamp the quotient to one.
  logic [VAL_W-1:0] fin [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dtag[i][VAL_W]) begin
        fin[i] = dtag[i][VAL_W-1:0];
      end else if (dtag[i][VAL_W+1] || dq[i] > ONE) begin
        fin[i] = ONE;
      end else begin
        fin[i] = dq[i];
      end
    end
  end

  assign busy_all = p0_v_r | (|cbusy) | l1_v_r | l2_v_r | y_busy | me_v_r | md_v_r
                  | (|dbusy);

  // ---------------------------------------------------------------------------
  // Output register: hold while stalled, load on advance.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && dv[0]) begin
      out_data_r.red_out   <= fin[0];
      out_data_r.green_out <= fin[1];
      out_data_r.blue_out  <= fin[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic lanes_ok, out_ok;

  assign lanes_ok = (cv[0] == cv[1]) && (cv[0] == cv[2]) && (dv[0] == dv[1])
                  && (dv[0] == dv[2]);
  assign out_ok   = (out_data_r.red_out <= ONE) && (out_data_r.green_out <= ONE)
                  && (out_data_r.blue_out <= ONE);

  `RLTC_ASSERT(a_lanes_aligned, clk, rst_n, lanes_ok)
  `RLTC_ASSERT(a_out_in_range, clk, rst_n, out_valid_r |-> out_ok)
  `RLTC_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, !adv, out_valid_r && $stable(out_data_r))

endmodule

// ----- hw/rtl/rltc_delay.sv -----
module rltc_delay #(
  parameter int W = rltc_pkg::VAL_W,
  parameter int D = rltc_pkg::CURVE_LAT
) (
  input  logic         clk,
  input  logic         adv,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] sh_r [D];

  always_ff @(posedge clk) begin
    if (adv) begin
      sh_r[0] <= d;
      for (int i = 1; i < D; i++) begin
        sh_r[i] <= sh_r[i-1];
      end
    end
  end

  assign q = sh_r[D-1];

endmodule

// ----- hw/rtl/rltc_div.sv -----
module rltc_div #(
  parameter int DW = rltc_pkg::VAL_W,
  parameter int QW = rltc_pkg::QUO_W,
  parameter int TW = rltc_pkg::VAL_W
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_v,
  input  logic [DW+QW-1:0] num,
  input  logic [DW-1:0]   den,
  input  logic [TW-1:0]   tag,
  output logic            out_v,
  output logic [QW-1:0]   quo,
  output logic [TW-1:0]   out_tag,
  output logic            busy
);
  // Restoring division, one quotient bit per stage. The upper DW bits of num
  // must be below den.
  logic            v_r   [QW];
  logic [DW-1:0]   rem_r [QW];
  logic [QW-1:0]   lq_r  [QW];
  logic [DW-1:0]   den_r [QW];
  logic [TW-1:0]   tag_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          v_i;
    logic [DW-1:0] rem_i;
    logic [QW-1:0] lq_i;
    logic [DW-1:0] den_i;
    logic [TW-1:0] tag_i;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_i   = in_v;
      assign rem_i = num[DW+QW-1:QW];
      assign lq_i  = num[QW-1:0];
      assign den_i = den;
      assign tag_i = tag;
    end else begin : g_next
      assign v_i   = v_r[k-1];
      assign rem_i = rem_r[k-1];
      assign lq_i  = lq_r[k-1];
      assign den_i = den_r[k-1];
      assign tag_i = tag_r[k-1];
    end

    assign t    = {rem_i, lq_i[QW-1]};
    assign diff = t - {1'b0, den_i};
    assign ge   = (t >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
        lq_r[k]  <= {lq_i[QW-2:0], ge};
        den_r[k] <= den_i;
        tag_r[k] <= tag_i;
      end
    end
  end

  always_comb begin
    busy = 1'b0;
    for (int i = 0; i < QW; i++) begin
      busy = busy | v_r[i];
    end
  end

  assign out_v   = v_r[QW-1];
  assign quo     = lq_r[QW-1];
  assign out_tag = tag_r[QW-1];

endmodule

// ----- hw/rtl/rltc_curve.sv -----
module rltc_curve #(
  parameter int             MAX_POINTS = rltc_pkg::MAX_POINTS_DEF,
  parameter rltc_pkg::crv_t CURVE_ID   = rltc_pkg::CRV_RED
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  rltc_pkg::pt_wr_t             wr,
  input  logic [rltc_pkg::CNT_W-1:0]   count,
  input  logic                         in_v,
  input  logic [rltc_pkg::VAL_W-1:0]   in_x,
  output logic                         out_v,
  output logic [rltc_pkg::VAL_W-1:0]   out_y,
  output logic                         busy
);
  import rltc_pkg::*;

  localparam int NW = $clog2(MAX_POINTS + 1);

  logic [VAL_W-1:0] px_r [MAX_POINTS];
  logic [VAL_W-1:0] py_r [MAX_POINTS];

  logic [NW-1:0]         n;
  logic [MAX_POINTS-1:0] is_last, lt, pre, sel;
  logic [VAL_W-1:0]      last_x, last_y, lx, ly, rx, ry, dval;
  logic                  dir;

  // point table
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (wr.en && wr.sel == CURVE_ID && int'(wr.idx) == i) begin
        px_r[i] <= wr.x;
        py_r[i] <= wr.y;
      end
    end
  end

  assign n = (int'(count) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(count);

  // segment search: first inner point right of x, else the last point
  always_comb begin
    lt     = '0;
    last_x = '0;
    last_y = '0;
    lx     = '0;
    ly     = '0;
    rx     = '0;
    ry     = '0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      is_last[i] = (int'(n) == i + 1);
    end
    for (int i = 1; i < MAX_POINTS; i++) begin
      lt[i] = (i + 1 < int'(n)) && (in_x < px_r[i]);
    end
    for (int i = 0; i < MAX_POINTS; i++) begin
      pre[i] = 1'b0;
      for (int j = 0; j < i; j++) begin
        pre[i] = pre[i] | lt[j];
      end
    end
    sel[0] = 1'b0;
    for (int i = 1; i < MAX_POINTS; i++) begin
      sel[i] = (lt[i] && !pre[i]) || (!(|lt) && is_last[i]);
    end
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (is_last[i]) begin
        last_x = last_x | px_r[i];
        last_y = last_y | py_r[i];
      end
    end
    for (int i = 1; i < MAX_POINTS; i++) begin
      if (sel[i]) begin
        lx = lx | px_r[i-1];
        ly = ly | py_r[i-1];
        rx = rx | px_r[i];
        ry = ry | py_r[i];
      end
    end
    dir  = 1'b1;
    dval = '0;
    if (n == '0) begin
      dval = in_x;
    end else if (in_x <= px_r[0]) begin
      dval = py_r[0];
    end else if (in_x >= last_x) begin
      dval = last_y;
    end else begin
      dir = 1'b0;
    end
  end

  // stage A: neighbours
  logic             a_v_r, a_dir_r;
  logic [VAL_W-1:0] a_x_r, a_dval_r, a_lx_r, a_ly_r, a_rx_r, a_ry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_x_r    <= in_x;
      a_dir_r  <= dir;
      a_dval_r <= dval;
      a_lx_r   <= lx;
      a_ly_r   <= ly;
      a_rx_r   <= rx;
      a_ry_r   <= ry;
    end
  end

  // stage B: differences; a direct answer goes through with a zero offset
  logic             b_neg;
  logic [VAL_W-1:0] b_base, b_dy, b_dx, b_den;

  always_comb begin
    b_base = a_ly_r;
    b_neg  = 1'b0;
    b_dy   = '0;
    b_dx   = '0;
    b_den  = VAL_W'(1);
    if (a_dir_r) begin
      b_base = a_dval_r;
    end else if (a_rx_r > a_lx_r && a_x_r >= a_lx_r) begin
      b_neg = (a_ry_r < a_ly_r);
      b_dy  = b_neg ? (a_ly_r - a_ry_r) : (a_ry_r - a_ly_r);
      b_dx  = a_x_r - a_lx_r;
      b_den = a_rx_r - a_lx_r;
    end
  end

  logic             b_v_r, b_neg_r;
  logic [VAL_W-1:0] b_base_r, b_dy_r, b_dx_r, b_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_neg_r  <= b_neg;
      b_base_r <= b_base;
      b_dy_r   <= b_dy;
      b_dx_r   <= b_dx;
      b_den_r  <= b_den;
    end
  end

  // stage C: offset numerator
  logic              c_v_r, c_neg_r;
  logic [PROD_W-1:0] c_prod_r;
  logic [VAL_W-1:0]  c_base_r, c_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (adv) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_prod_r <= PROD_W'(b_dy_r) * PROD_W'(b_dx_r);
      c_neg_r  <= b_neg_r;
      c_base_r <= b_base_r;
      c_den_r  <= b_den_r;
    end
  end

  logic             d_v, d_busy;
  logic [QUO_W-1:0] d_q;
  logic [VAL_W:0]   d_tag;

  rltc_div #(
    .DW(VAL_W),
    .QW(QUO_W),
    .TW(VAL_W + 1)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_v    (c_v_r),
    .num     (c_prod_r),
    .den     (c_den_r),
    .tag     ({c_base_r, c_neg_r}),
    .out_v   (d_v),
    .quo     (d_q),
    .out_tag (d_tag),
    .busy    (d_busy)
  );

  // stage F: apply offset toward the left y
  logic             f_v_r;
  logic [VAL_W-1:0] f_y_r, f_base;

  assign f_base = d_tag[VAL_W:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (adv) begin
      f_v_r <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (d_tag[0]) begin
        f_y_r <= (d_q > f_base) ? '0 : (f_base - d_q);
      end else begin
        f_y_r <= f_base + d_q;
      end
    end
  end

  assign out_v = f_v_r;
  assign out_y = f_y_r;
  assign busy  = a_v_r | b_v_r | c_v_r | d_busy | f_v_r;

endmodule

// ----- dv/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rltc_pkg::*;

  localparam int          NPTS      = 16;
  localparam int          CYC_LIMIT = 4000000;
  // margin to wait once the last expected pixel has come out
  localparam int          SETTLE    = 100;
  localparam logic [16:0] FULL      = 17'h10000;
  localparam logic [16:0] TOP       = 17'h1FFFF;
  localparam longint unsigned K_R = 13933;
  localparam longint unsigned K_G = 46871;
  localparam longint unsigned K_B = 4732;

  typedef enum int {
    REG_RED_CNT   = 0,
    REG_GREEN_CNT = 1,
    REG_BLUE_CNT  = 2,
    REG_LUMA_CNT  = 3
  } reg_idx_t;

  // directed stimulus row: expected pixel typed in only where 'fixed' is set
  typedef struct {
    in_item_t  item;
    bit        fixed;
    out_item_t want;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  in_item_t  in_data;
  out_item_t out_data;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata, cfg_prdata;

  rgb_luma_tone_curve_unit dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  // shadow of the block: point tables and the point counts
  logic [16:0] tab_x [4*NPTS];
  logic [16:0] tab_y [4*NPTS];
  logic [4:0]  pt_cnt [4];

  out_item_t pixel_q[$];
  int        n_err;
  int        cycles;
  bit        calm;
  int        stall_left;

  task automatic report(input string what, input logic [16:0] got, input logic [16:0] want);
    $display("tb: mismatch %s got %h want %h at cycle %0d", what, got, want, cycles);
    n_err++;
  endtask

  function automatic logic [16:0] clip(input logic [16:0] v);
    return (v > FULL) ? FULL : v;
  endfunction

  // piecewise-linear lookup through one curve
  function automatic logic [16:0] curve_at(input int c, input logic [16:0] x);
    int n, i;
    longint unsigned lx, ly, rx, ry, q;
    n = (pt_cnt[c] > NPTS) ? NPTS : pt_cnt[c];
    if (n == 0) return x;
    if (x <= tab_x[c*NPTS]) return tab_y[c*NPTS];
    if (x >= tab_x[c*NPTS+n-1]) return tab_y[c*NPTS+n-1];
    for (i = 1; i < n - 1; i++)
      if (x < tab_x[c*NPTS+i]) break;
    lx = tab_x[c*NPTS+i-1];
    ly = tab_y[c*NPTS+i-1];
    rx = tab_x[c*NPTS+i];
    ry = tab_y[c*NPTS+i];
    // degenerate segment from an unsorted table
    if (rx <= lx || x < lx) return ly;
    if (ry >= ly) begin
      q = (ry - ly) * (x - lx) / (rx - lx);
      return 17'(ly + q);
    end
    q = (ly - ry) * (x - lx) / (rx - lx);
    return (q > ly) ? 17'd0 : 17'(ly - q);
  endfunction

  function automatic out_item_t map_pixel(input in_item_t it);
    longint unsigned r, g, b, lum, adj;
    out_item_t o;
    r   = curve_at(CRV_RED, clip(it.red_in));
    g   = curve_at(CRV_GREEN, clip(it.green_in));
    b   = curve_at(CRV_BLUE, clip(it.blue_in));
    lum = (K_R * r + K_G * g + K_B * b + 32768) >> 16;
    if (lum > FULL) lum = FULL;
    adj = curve_at(CRV_LUMA, 17'(lum));
    if (lum > 0) begin
      r = r * adj / lum; if (r > FULL) r = FULL;
      g = g * adj / lum; if (g > FULL) g = FULL;
      b = b * adj / lum; if (b > FULL) b = FULL;
    end else begin
      // zero luma: every channel takes the adjusted luma
      r = adj; g = adj; b = adj;
    end
    o.red_out   = 17'(r);
    o.green_out = 17'(g);
    o.blue_out  = 17'(b);
    return o;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // cycle counter and run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // result side: check each transfer, then pick the next stall value
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        report("unexpected", out_data.red_out, 17'd0);
      end else begin
        out_item_t w;
        w = pixel_q.pop_front();
        if (out_data.red_out !== w.red_out) report("red", out_data.red_out, w.red_out);
        if (out_data.green_out !== w.green_out)
          report("green", out_data.green_out, w.green_out);
        if (out_data.blue_out !== w.blue_out) report("blue", out_data.blue_out, w.blue_out);
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // offer one item, hold it until transfer, then update the shadow
  task automatic send(input in_item_t it, input bit fixed = 0, input out_item_t want = '0);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (it.op == OP_WRITE) begin
      tab_x[int'(it.curve_sel)*NPTS + it.point_index] = clip(it.point_x);
      tab_y[int'(it.curve_sel)*NPTS + it.point_index] = clip(it.point_y);
    end else begin
      pixel_q = {pixel_q, (fixed ? want : map_pixel(it))};
    end
  endtask

  // drop valid and wait until the pipe is empty, including any point write
  task automatic drain();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t r, input logic [4:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(4 * int'(r));
    cfg_pwdata  <= CFG_DW'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    pt_cnt[int'(r)] = v;
  endtask

  function automatic in_item_t noise_item();
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom}));
    return it;
  endfunction

  function automatic in_item_t point_item(input int c, input int k, input logic [16:0] x,
                                          input logic [16:0] y);
    in_item_t it;
    it = noise_item();
    it.op          = OP_WRITE;
    it.curve_sel   = crv_t'(c);
    it.point_index = 4'(k);
    it.point_x     = x;
    it.point_y     = y;
    return it;
  endfunction

  // pixels: mostly in range, sometimes zero or over-range
  function automatic logic [16:0] chan();
    case ($urandom_range(0, 9))
      0:       return 17'd0;
      1:       return 17'($urandom);
      2:       return FULL;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic in_item_t pixel_item();
    in_item_t it;
    it = noise_item();
    it.op       = OP_MAP;
    it.red_in   = chan();
    it.green_in = chan();
    it.blue_in  = chan();
    return it;
  endfunction

  // load all four curves; mode 0 sorted, 1 sorted past 1.0, 2 unsorted
  task automatic load_curves(input int mode);
    logic [16:0] x, y;
    for (int c = 0; c < 4; c++)
      for (int k = 0; k < NPTS; k++) begin
        case (mode)
          0:       x = 17'(k * 4096 + $urandom_range(0, 4095));
          1:       x = 17'(k * 4400 + $urandom_range(0, 4399));
          default: x = 17'($urandom);
        endcase
        y = ($urandom_range(0, 5) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
        send(point_item(c, k, x, y));
      end
  endtask

  function automatic logic [4:0] pick_count(input int ph);
    case (ph)
      0:       return 5'd16;
      1:       return 5'd31;   // above the limit, acts as full table
      2:       return 5'd0;
      3:       return 5'd1;
      4:       return 5'd2;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic out_item_t px(input logic [16:0] r, input logic [16:0] g,
                                   input logic [16:0] b);
    out_item_t o;
    o.red_out = r; o.green_out = g; o.blue_out = b;
    return o;
  endfunction

  function automatic in_item_t pin(input logic [16:0] r, input logic [16:0] g,
                                   input logic [16:0] b);
    in_item_t it;
    it = '0;
    it.op = OP_MAP; it.red_in = r; it.green_in = g; it.blue_in = b;
    return it;
  endfunction

  row_t rows[$];

  // append one directed row to the table
  task automatic add_row(input in_item_t it, input bit fixed, input out_item_t want);
    row_t r;
    r.item  = it;
    r.fixed = fixed;
    r.want  = want;
    rows = {rows, r};
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    calm        = 1'b0;
    stall_left  = 0;
    n_err       = 0;
    for (int c = 0; c < 4; c++) pt_cnt[c] = '0;
    for (int e = 0; e < 4*NPTS; e++) begin
      tab_x[e] = '0;
      tab_y[e] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: all counts zero after reset, so every curve is the identity
    add_row(pin(0, 0, 0), 1, px(0, 0, 0));
    add_row(pin(FULL, FULL, FULL), 1, px(FULL, FULL, FULL));
    add_row(pin(TOP, 0, 17'h10001), 1, px(FULL, 0, FULL));
    add_row(pin(TOP, TOP, TOP), 1, px(FULL, FULL, FULL));
    add_row(pin(1, 0, 0), 1, px(0, 0, 0));   // luma rounds to zero
    add_row(pin(0, 1, 0), 1, px(0, 1, 0));
    add_row(pin(12345, 0, 0), 1, px(12345, 0, 0));
    add_row(pin(17'h0AAAA, 17'h15555, 17'h05555), 0, '0);
    add_row(point_item(CRV_RED, 0, TOP, TOP), 0, '0);
    add_row(point_item(CRV_GREEN, 15, 0, 0), 0, '0);
    add_row(point_item(CRV_BLUE, 5, 17'h0AAAA, 17'h15555), 0, '0);
    add_row(point_item(CRV_LUMA, 10, 17'h15555, 17'h0AAAA), 0, '0);
    add_row(pin(17'h08000, 17'h04000, 17'h0C000), 0, '0);
    foreach (rows[i]) send(rows[i].item, rows[i].fixed, rows[i].want);

    // random phases: reload tables, set counts while idle, stream pixels
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 11) calm = 1'b1;
      if (ph == 0 || $urandom_range(0, 2) == 0)
        load_curves((ph == 0) ? 0 : $urandom_range(0, 2));
      drain();
      reg_write(REG_RED_CNT, pick_count(ph));
      reg_write(REG_GREEN_CNT, pick_count(ph));
      reg_write(REG_BLUE_CNT, pick_count(ph));
      reg_write(REG_LUMA_CNT, pick_count(ph));
      for (int n = 0; n < 120; n++) begin
        // occasional stray point write in the middle of the stream
        if ($urandom_range(0, 19) == 0)
          send(point_item($urandom_range(0, 3), $urandom_range(0, 15),
                          17'($urandom), 17'($urandom)));
        send(pixel_item());
      end
    end

    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (n_err == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- rgb_luma_tone_curve_unit.f -----
+incdir+hw/rtl
hw/rtl/rltc_pkg.sv
hw/rtl/rltc_delay.sv
hw/rtl/rltc_div.sv
hw/rtl/rltc_curve.sv
hw/rtl/rgb_luma_tone_curve_unit.sv
dv/tb.sv
